### rtl/rab_pkg.sv
// Shared types and constants for the RGBA alpha blend unit.
package rab_pkg;

    localparam int unsigned NumLanes = 4;
    localparam int unsigned ChanW    = 8;
    localparam int unsigned ProdW    = 2 * ChanW;
    localparam int unsigned PixelW   = NumLanes * ChanW;

    localparam logic [ChanW-1:0] ChMax     = 8'hFF;
    localparam logic [ProdW-1:0] FullScale = 16'd65025;

    typedef enum logic [1:0] {
        FACT_ZERO        = 2'd0,
        FACT_ONE         = 2'd1,
        FACT_SRC_A       = 2'd2,
        FACT_ONE_MINUS_A = 2'd3
    } t_factor;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_SUB     = 2'd1,
        OP_REV_SUB = 2'd2,
        OP_ZERO    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_BLEND_EN  = 3'd0,
        CFG_COLOR_SRC = 3'd1,
        CFG_COLOR_DST = 3'd2,
        CFG_COLOR_OP  = 3'd3,
        CFG_ALPHA_SRC = 3'd4,
        CFG_ALPHA_DST = 3'd5,
        CFG_ALPHA_OP  = 3'd6,
        CFG_UNUSED    = 3'd7
    } t_cfg_idx;

endpackage

### rtl/rgba_alpha_blend_unit.sv
// RGBA8888 blend datapath: four-stage pipeline, one pixel per clock when not stalled.
//
//   channel  direction  handshake                    payload
//   in       sink       i_valid / o_stall            i_src_color, i_dst_color
//   out      source     o_valid / i_stall            o_blended_color
//   cfg      sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Stages in order: factor select, 8x8 multiply, combine and clamp,
// divide by 255. A new item enters every cycle unless o_stall is high.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse under stall. o_stall rises only when all four stages hold.
// Synchronous reset clears the valid bits and returns config to its defaults; config is always ready.
module rgba_alpha_blend_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [rab_pkg::PixelW-1:0]     i_src_color,
    input  logic [rab_pkg::PixelW-1:0]     i_dst_color,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rab_pkg::PixelW-1:0]     o_blended_color,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [1:0]                     i_cfg_data
);

    localparam int unsigned L  = rab_pkg::NumLanes;
    localparam int unsigned CW = rab_pkg::ChanW;
    localparam int unsigned PW = rab_pkg::ProdW;

    // configuration
    logic              r_blend_en;
    rab_pkg::t_factor  r_color_src, r_color_dst, r_alpha_src, r_alpha_dst;
    rab_pkg::t_op      r_color_op, r_alpha_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_en  <= 1'b0;
            r_color_src <= rab_pkg::FACT_ONE;
            r_color_dst <= rab_pkg::FACT_ZERO;
            r_color_op  <= rab_pkg::OP_ADD;
            r_alpha_src <= rab_pkg::FACT_ONE;
            r_alpha_dst <= rab_pkg::FACT_ZERO;
            r_alpha_op  <= rab_pkg::OP_ADD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rab_pkg::t_cfg_idx'(i_cfg_index))
                rab_pkg::CFG_BLEND_EN:  r_blend_en  <= i_cfg_data[0];
                rab_pkg::CFG_COLOR_SRC: r_color_src <= rab_pkg::t_factor'(i_cfg_data);
                rab_pkg::CFG_COLOR_DST: r_color_dst <= rab_pkg::t_factor'(i_cfg_data);
                rab_pkg::CFG_COLOR_OP:  r_color_op  <= rab_pkg::t_op'(i_cfg_data);
                rab_pkg::CFG_ALPHA_SRC: r_alpha_src <= rab_pkg::t_factor'(i_cfg_data);
                rab_pkg::CFG_ALPHA_DST: r_alpha_dst <= rab_pkg::t_factor'(i_cfg_data);
                rab_pkg::CFG_ALPHA_OP:  r_alpha_op  <= rab_pkg::t_op'(i_cfg_data);
                default: ;
            endcase
        end
    end

    function automatic logic [CW-1:0] fac_value(rab_pkg::t_factor code,
                                                logic [CW-1:0] alpha);
        logic [CW-1:0] v;
        case (code)
            rab_pkg::FACT_ONE:         v = rab_pkg::ChMax;
            rab_pkg::FACT_SRC_A:       v = alpha;
            rab_pkg::FACT_ONE_MINUS_A: v = rab_pkg::ChMax - alpha;
            default:                   v = '0;
        endcase
        return v;
    endfunction

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    assign w_adv4  = !r_v4 || !i_stall;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // stage 1: channel values and per-lane factors
    logic [CW-1:0]  r_s1_s  [L];
    logic [CW-1:0]  r_s1_d  [L];
    logic [CW-1:0]  r_s1_sf [L];
    logic [CW-1:0]  r_s1_df [L];
    rab_pkg::t_op   r_s1_op [L];

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            for (int i = 0; i < L; i++) begin
                r_s1_s[i] <= i_src_color[i*CW +: CW];
                r_s1_d[i] <= i_dst_color[i*CW +: CW];
                if (!r_blend_en) begin
                    // pass-through: s*255 + 0, divided by 255 gives s back
                    r_s1_sf[i] <= rab_pkg::ChMax;
                    r_s1_df[i] <= '0;
                    r_s1_op[i] <= rab_pkg::OP_ADD;
                end else if (i == 0) begin
                    r_s1_sf[i] <= fac_value(r_alpha_src, i_src_color[CW-1:0]);
                    r_s1_df[i] <= fac_value(r_alpha_dst, i_src_color[CW-1:0]);
                    r_s1_op[i] <= r_alpha_op;
                end else begin
                    r_s1_sf[i] <= fac_value(r_color_src, i_src_color[CW-1:0]);
                    r_s1_df[i] <= fac_value(r_color_dst, i_src_color[CW-1:0]);
                    r_s1_op[i] <= r_color_op;
                end
            end
        end
    end

    // stage 2: products
    logic [PW-1:0]  r_s2_sp [L];
    logic [PW-1:0]  r_s2_dp [L];
    rab_pkg::t_op   r_s2_op [L];

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            for (int i = 0; i < L; i++) begin
                r_s2_sp[i] <= r_s1_s[i] * r_s1_sf[i];
                r_s2_dp[i] <= r_s1_d[i] * r_s1_df[i];
                r_s2_op[i] <= r_s1_op[i];
            end
        end
    end

    // stage 3: combine and clamp to 0..65025
    logic [PW-1:0] r_s3_sum [L];
    logic [PW-1:0] n_s3_sum [L];
    logic [PW:0]   w_add    [L];

    always_comb begin
        for (int i = 0; i < L; i++) begin
            w_add[i] = {1'b0, r_s2_sp[i]} + {1'b0, r_s2_dp[i]};
            case (r_s2_op[i])
                rab_pkg::OP_ADD:
                    n_s3_sum[i] = (w_add[i] > {1'b0, rab_pkg::FullScale})
                                ? rab_pkg::FullScale : w_add[i][PW-1:0];
                rab_pkg::OP_SUB:
                    n_s3_sum[i] = (r_s2_sp[i] > r_s2_dp[i])
                                ? r_s2_sp[i] - r_s2_dp[i] : '0;
                rab_pkg::OP_REV_SUB:
                    n_s3_sum[i] = (r_s2_dp[i] > r_s2_sp[i])
                                ? r_s2_dp[i] - r_s2_sp[i] : '0;
                default:
                    n_s3_sum[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            for (int i = 0; i < L; i++) begin
                r_s3_sum[i] <= n_s3_sum[i];
            end
        end
    end

    // stage 4: floor divide by 255 as (x + (x >> 8) + 1) >> 8, exact for 0..65025
    logic [PW:0]        w_div [L];
    logic [L*CW-1:0]    r_out;

    always_comb begin
        for (int i = 0; i < L; i++) begin
            w_div[i] = {1'b0, r_s3_sum[i]} + {{(PW+1-CW){1'b0}}, r_s3_sum[i][PW-1:CW]}
                     + {{PW{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            for (int i = 0; i < L; i++) begin
                r_out[i*CW +: CW] <= w_div[i][PW-1:CW];
            end
        end
    end

    assign o_valid         = r_v4;
    assign o_blended_color = r_out;

endmodule

### rtl/rab_checker.sv
// Port-level checks for the RGBA alpha blend unit, bound to the top level.
module rab_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [rab_pkg::PixelW-1:0]  o_blended_color,
    input logic                        o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blended_color))
        else $error("stalled result changed or dropped");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // with the output stage empty every stage can advance
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage empty");

    // input backs up only behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind rgba_alpha_blend_unit rab_checker u_rab_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_blended_color (o_blended_color),
    .o_cfg_ready     (o_cfg_ready)
);
